@@ rtl/mcu_8bit_alu_with_flags_core_assert.svh @@
// assertion macros for the byte alu core and its checker
// no dependencies; included by the checker file
`ifndef MCU_8BIT_ALU_WITH_FLAGS_CORE_ASSERT_SVH
`define MCU_8BIT_ALU_WITH_FLAGS_CORE_ASSERT_SVH

// property checked at every edge, reset included
`define MCU_ALU_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mcu alu assertion failed");

// property checked outside reset
`define MCU_ALU_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mcu alu assertion failed");

`endif

@@ rtl/mcu_alu_pkg.sv @@
// types and operation codes shared by the byte alu core
// no dependencies
`timescale 1ns / 1ps

package mcu_alu_pkg;

   typedef enum logic [4:0] {
      OP_ADD          = 5'd0,
      OP_AND          = 5'd1,
      OP_BITCLR       = 5'd2,
      OP_BTST_SKIPCLR = 5'd3,
      OP_BITSET       = 5'd4,
      OP_BTST_SKIPSET = 5'd5,
      OP_CLR          = 5'd6,
      OP_COM          = 5'd7,
      OP_DEC          = 5'd8,
      OP_DECSZ        = 5'd9,
      OP_INC          = 5'd10,
      OP_INCSZ        = 5'd11,
      OP_OR           = 5'd12,
      OP_MOVA_Z       = 5'd13,
      OP_MOVB         = 5'd14,
      OP_PASS         = 5'd15,
      OP_RLC          = 5'd16,
      OP_RRC          = 5'd17,
      OP_SUB          = 5'd18,
      OP_SWAP         = 5'd19,
      OP_XOR          = 5'd20
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [2:0] bit_sel;
      logic       carry_in;
      logic       digit_carry_in;
      logic       zero_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result_byte;
      logic       carry_out;
      logic       digit_carry_out;
      logic       zero_out;
      logic       skip_next;
   } rsp_type;

endpackage

@@ rtl/mcu_8bit_alu_with_flags_core.sv @@
// byte alu core: one item per operation, with c, dc, z and skip flags
// input register, mcu_alu_exec, result register
// depends on mcu_alu_pkg and mcu_alu_exec
//
// usage:
//   req_ channel: operation code, two byte operands, bit select and the
//   incoming c, dc and z flags; an item is taken when req_valid and
//   req_ready are both high.
//   rsp_ channel: result byte, updated flags and the skip flag, one result
//   item for every request item, in order.
//   order: the accepting edge loads the input register; the alu output then
//   lands in the result register, which raises rsp_valid, once the result
//   register is empty or its result is being taken.
//   throughput: one item per cycle while rsp_ready stays high; the alu
//   evaluates in a single pass between the two registers.
//   stall: when the result waits, the input register still takes an item if
//   it is empty; once it is full, req_ready stays low until the result is taken.
//   reset: both registers empty, req_ready high, rsp_valid low.
`timescale 1ns / 1ps

module mcu_8bit_alu_with_flags_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_operation,
   input  logic [7:0] req_operand_a,
   input  logic [7:0] req_operand_b,
   input  logic [2:0] req_bit_sel,
   input  logic       req_carry_in,
   input  logic       req_digit_carry_in,
   input  logic       req_zero_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result_byte,
   output logic       rsp_carry_out,
   output logic       rsp_digit_carry_out,
   output logic       rsp_zero_out,
   output logic       rsp_skip_next
);

   mcu_alu_pkg::req_type req_ff;
   mcu_alu_pkg::req_type req_in;
   logic                 req_valid_ff;
   logic                 req_valid_in;
   mcu_alu_pkg::rsp_type rsp_ff;
   mcu_alu_pkg::rsp_type rsp_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   mcu_alu_pkg::rsp_type alu_rsp;
   logic                 advance;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      req_in.operation      = mcu_alu_pkg::op_type'(req_operation);
      req_in.operand_a      = req_operand_a;
      req_in.operand_b      = req_operand_b;
      req_in.bit_sel        = req_bit_sel;
      req_in.carry_in       = req_carry_in;
      req_in.digit_carry_in = req_digit_carry_in;
      req_in.zero_in        = req_zero_in;
      req_valid_in          = req_ready ? req_valid : req_valid_ff;
      rsp_in                = alu_rsp;
      rsp_valid_in          = advance ? req_valid_ff : rsp_valid_ff;
   end

   mcu_alu_exec u_exec (
      .req (req_ff),
      .rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_byte     = rsp_ff.result_byte;
   assign rsp_carry_out       = rsp_ff.carry_out;
   assign rsp_digit_carry_out = rsp_ff.digit_carry_out;
   assign rsp_zero_out        = rsp_ff.zero_out;
   assign rsp_skip_next       = rsp_ff.skip_next;

endmodule

@@ rtl/mcu_alu_exec.sv @@
// combinational byte alu: result, c, dc, z and skip for one item
// depends on mcu_alu_pkg
`timescale 1ns / 1ps

module mcu_alu_exec (
   input  mcu_alu_pkg::req_type req,
   output mcu_alu_pkg::rsp_type rsp
);

   logic [8:0] sum;
   logic [8:0] diff;
   logic [4:0] nib_sum;
   logic [4:0] nib_diff;
   logic [7:0] inc_val;
   logic [7:0] dec_val;
   logic [7:0] bit_mask;
   logic [7:0] res;
   logic       c_next;
   logic       dc_next;
   logic       skip;
   logic       upd_z;

   assign sum      = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign diff     = {1'b0, req.operand_a} - {1'b0, req.operand_b};
   assign nib_sum  = {1'b0, req.operand_a[3:0]} + {1'b0, req.operand_b[3:0]};
   assign nib_diff = {1'b0, req.operand_a[3:0]} - {1'b0, req.operand_b[3:0]};
   assign inc_val  = req.operand_a + 8'd1;
   assign dec_val  = req.operand_a - 8'd1;
   assign bit_mask = 8'd1 << req.bit_sel;

   always_comb begin
      res     = req.operand_a;
      c_next  = req.carry_in;
      dc_next = req.digit_carry_in;
      skip    = 1'b0;
      upd_z   = 1'b0;
      unique case (req.operation)
         mcu_alu_pkg::OP_ADD: begin
            res     = sum[7:0];
            c_next  = sum[8];
            dc_next = nib_sum[4];
            upd_z   = 1'b1;
         end
         mcu_alu_pkg::OP_SUB: begin
            // carry and digit carry mean no borrow
            res     = diff[7:0];
            c_next  = ~diff[8];
            dc_next = ~nib_diff[4];
            upd_z   = 1'b1;
         end
         mcu_alu_pkg::OP_AND: begin
            res   = req.operand_a & req.operand_b;
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_OR: begin
            res   = req.operand_a | req.operand_b;
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_XOR: begin
            res   = req.operand_a ^ req.operand_b;
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_COM: begin
            res   = ~req.operand_a;
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_CLR: begin
            res   = 8'd0;
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_MOVA_Z: begin
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_MOVB: begin
            res = req.operand_b;
         end
         mcu_alu_pkg::OP_DEC: begin
            res   = dec_val;
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_INC: begin
            res   = inc_val;
            upd_z = 1'b1;
         end
         mcu_alu_pkg::OP_DECSZ: begin
            res  = dec_val;
            skip = (dec_val == 8'd0);
         end
         mcu_alu_pkg::OP_INCSZ: begin
            res  = inc_val;
            skip = (inc_val == 8'd0);
         end
         mcu_alu_pkg::OP_RLC: begin
            res    = {req.operand_a[6:0], req.carry_in};
            c_next = req.operand_a[7];
         end
         mcu_alu_pkg::OP_RRC: begin
            res    = {req.carry_in, req.operand_a[7:1]};
            c_next = req.operand_a[0];
         end
         mcu_alu_pkg::OP_SWAP: begin
            res = {req.operand_a[3:0], req.operand_a[7:4]};
         end
         mcu_alu_pkg::OP_BITCLR: begin
            res = req.operand_a & ~bit_mask;
         end
         mcu_alu_pkg::OP_BITSET: begin
            res = req.operand_a | bit_mask;
         end
         mcu_alu_pkg::OP_BTST_SKIPCLR: begin
            skip = ((req.operand_a & bit_mask) == 8'd0);
         end
         mcu_alu_pkg::OP_BTST_SKIPSET: begin
            skip = ((req.operand_a & bit_mask) != 8'd0);
         end
         // pass and unused codes keep a and the c, dc and z flags; skip stays low
         default: begin
            res = req.operand_a;
         end
      endcase
   end

   assign rsp.result_byte     = res;
   assign rsp.carry_out       = c_next;
   assign rsp.digit_carry_out = dc_next;
   assign rsp.zero_out        = upd_z ? (res == 8'd0) : req.zero_in;
   assign rsp.skip_next       = skip;

endmodule

@@ rtl/mcu_alu_checker.sv @@
// port-level checker for the byte alu core, bound to the top level
// depends on mcu_8bit_alu_with_flags_core_assert.svh
`timescale 1ns / 1ps
`include "mcu_8bit_alu_with_flags_core_assert.svh"

module mcu_alu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_result_byte,
   input logic       rsp_carry_out,
   input logic       rsp_digit_carry_out,
   input logic       rsp_zero_out,
   input logic       rsp_skip_next
);

   // reset empties the result register
   `MCU_ALU_ASSERT(a_reset_empty, clock, reset |=> !rsp_valid)

   // stalled result keeps its payload
   `MCU_ALU_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_result_byte, rsp_carry_out, rsp_digit_carry_out, rsp_zero_out, rsp_skip_next})))

   // an item taken while rsp_ready stays high reaches the output through the input and result registers
   `MCU_ALU_ASSERT_RST(a_latency, clock, reset, (req_valid && req_ready && rsp_ready) ##1 rsp_ready |=> rsp_valid)

   // a fresh result always stems from an item taken earlier and held in the input register
   `MCU_ALU_ASSERT_RST(a_no_phantom, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))

endmodule

bind mcu_8bit_alu_with_flags_core mcu_alu_checker u_mcu_alu_checker (.*);
